// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the day number converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHDN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shdn: assertion failed");
`define SHDN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("shdn: assertion failed");
`else
`define SHDN_ASSERT(label, clk, rst_n, prop)
`define SHDN_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/shdn_pkg.sv =====
// Types, constants and helper functions of the Solar Hijri day number converter.
package shdn_pkg;

    localparam int STAGES = 16;

    localparam logic OP_TO_DN   = 1'b0;
    localparam logic OP_TO_DATE = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [2:0] FEST_NONE   = 3'd0;
    localparam logic [2:0] FEST_NOWRUZ = 3'd1;
    localparam logic [2:0] FEST_SIZDAH = 3'd2;
    localparam logic [2:0] FEST_YALDA  = 3'd3;
    localparam logic [2:0] FEST_SURI   = 3'd4;

    // cycle arithmetic
    localparam int CYCLE_YEARS  = 2820;
    localparam int CYCLE_DAYS   = 1029983;
    localparam int BASE_YEAR    = 474;
    localparam int EPOCH_BEFORE = 1948319;
    localparam int YEAR_FRAC_DEN = 1028522;
    // reciprocals: floor(x / d) = (x * M) >> K over the value ranges used here
    localparam int RECIP_2820   = 380760;     // K = 30
    localparam int RECIP_CYCLE  = 34160149;   // K = 45
    localparam int RECIP_366    = 1466861;    // K = 29
    localparam int RECIP_11     = 5958;       // K = 16
    localparam int RECIP_31     = 2115;       // K = 16
    localparam int RECIP_30     = 2185;       // K = 16
    localparam int RECIP_7      = 19173962;   // K = 27

    typedef struct packed {
        logic               operation;
        logic signed [15:0] in_year;
        logic [3:0]         in_month;
        logic [4:0]         in_day;
        logic signed [23:0] in_day_number;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_year;
        logic [3:0]         out_month;
        logic [4:0]         out_day;
        logic signed [23:0] out_day_number;
        logic [2:0]         weekday;
        logic               is_leap;
        logic [4:0]         month_length;
        logic [8:0]         year_length;
        logic [2:0]         festival;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic               op;
        logic signed [16:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [25:0] dn;
        logic [16:0]        b0;
        logic [24:0]        b1;
        logic [4:0]         q0;
        logic [4:0]         q1;
        logic signed [4:0]  cyc;
        logic [11:0]        ey;
        logic [19:0]        cday;
        logic               last;
        logic [11:0]        a1;
        logic [8:0]         a2;
        logic [22:0]        num;
        logic [11:0]        ycyc;
        logic signed [24:0] dcyc;
        logic [21:0]        pf;
        logic [21:0]        pv;
        logic [9:0]         qf;
        logic [9:0]         qv;
        logic               leap;
        logic [20:0]        fy;
        logic [8:0]         yday;
        logic [24:0]        w7;
        logic [21:0]        qw;
        logic [2:0]         wd;
        logic [4:0]         mlen;
        logic [2:0]         fest;
        logic [1:0]         st;
    } t_work;

    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } t_pipe_ctl;

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        if (m <= 4'd6) begin
            d = 9'(31 * (int'(m) - 1));
        end else begin
            d = 9'(186 + 30 * (int'(m) - 7));
        end
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] l;
        if (m <= 4'd6) begin
            l = 5'd31;
        end else if (m <= 4'd11) begin
            l = 5'd30;
        end else begin
            l = leap ? 5'd30 : 5'd29;
        end
        return l;
    endfunction

    // x below 56
    function automatic logic [2:0] mod7_small(input logic [5:0] x);
        logic [5:0] r;
        r = x;
        if (r >= 6'd28) r = r - 6'd28;
        if (r >= 6'd14) r = r - 6'd14;
        if (r >= 6'd7)  r = r - 6'd7;
        return r[2:0];
    endfunction

endpackage

// ===== rtl/shdn_stream_if.sv =====
// Valid/ready stream interface carrying one payload item per transfer.
interface shdn_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/shdn_pipe_ctl.sv =====
// Stage load enables and valid bits of the converter pipeline; bubbles collapse on stall.
module shdn_pipe_ctl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output shdn_pkg::t_pipe_ctl   o_ctl
);
    logic [shdn_pkg::STAGES-1:0] r_valid;
    logic [shdn_pkg::STAGES-1:0] n_valid;
    logic [shdn_pkg::STAGES-1:0] load;

    always_comb begin
        load[shdn_pkg::STAGES-1] = !r_valid[shdn_pkg::STAGES-1] || i_out_ready;
        for (int k = shdn_pkg::STAGES - 2; k >= 0; k--) begin
            load[k] = !r_valid[k] || load[k+1];
        end
        n_valid[0] = load[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < shdn_pkg::STAGES; k++) begin
            n_valid[k] = load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.load  = load;
    assign o_ctl.valid = r_valid;
endmodule

// ===== rtl/solar_hijri_day_number_converter.sv =====
// Solar Hijri date <-> Julian day number converter, arithmetic 2820-year cycle.
// Input channel i_in (sink): one transfer = one conversion request. operation 0
//   converts in_year/in_month/in_day to a day number, operation 1 converts
//   in_day_number to a date. Unused fields are ignored.
// Output channel o_out (source): exactly one result per request, in order, with
//   date, day number, weekday (0 = Saturday), leap flag, month and year length,
//   festival code and status. A failed result carries zeros besides status.
// Pipeline: 16 register stages (cycle division by reciprocal multiply,
//   year-in-cycle search, year start and leap computation, month split,
//   weekday mod 7, festival).
// Throughput: one conversion per cycle while o_out.ready does not stall it;
//   all stages work in parallel, so the pipeline takes a new item each clock.
// Stall: when o_out.ready is low the last stage holds its result; earlier
//   stages keep filling any empty slots, and i_in.ready drops only once every
//   stage holds an item. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous): all stage valid bits clear, the pipeline
//   is empty and ready to accept on the first cycle after reset.
`include "assert_macros.svh"

module solar_hijri_day_number_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    shdn_stream_if.sink   i_in,
    shdn_stream_if.source o_out
);
    localparam int LAST = shdn_pkg::STAGES - 1;

    shdn_pkg::t_pipe_ctl ctl;
    shdn_pkg::t_work     r_stage [shdn_pkg::STAGES];
    shdn_pkg::t_work     n_stage [shdn_pkg::STAGES];
    shdn_pkg::t_in       din;

    logic signed [17:0] b0_sum;
    logic signed [25:0] b1_sum;
    logic [35:0]        prod0;
    logic [50:0]        prod1;
    logic [16:0]        rem0;
    logic [40:0]        prod2;
    logic [2:0]         cnt;
    logic signed [17:0] yr_raw;
    logic signed [17:0] yr_adj;
    logic [26:0]        prodf;
    logic [26:0]        prodv;
    logic [21:0]        remv;
    logic [21:0]        yday_sum;
    logic [7:0]         ydm1;
    logic [7:0]         ydm2;
    logic [19:0]        pm1;
    logic [19:0]        pm2;
    logic [3:0]         m_lo;
    logic [3:0]         m_hi;
    logic signed [25:0] w7_sum;
    logic [49:0]        prodw;
    logic [5:0]         wdl;
    logic [2:0]         back;
    logic [4:0]         wed;

    shdn_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_ctl       (ctl)
    );

    assign din        = i_in.data;
    assign i_in.ready = ctl.load[0];

    always_comb begin
        // stage 0: capture, offset operands for the cycle division
        n_stage[0]       = '0;
        n_stage[0].op    = din.operation;
        n_stage[0].year  = 17'(din.in_year);
        n_stage[0].month = din.in_month;
        n_stage[0].day   = din.in_day;
        n_stage[0].dn    = 26'(din.in_day_number);
        b0_sum = 18'(din.in_year) + ((din.in_year > 16'sd0) ? 18'sd33366 : 18'sd33367);
        n_stage[0].b0 = b0_sum[16:0];
        b1_sum = 26'(din.in_day_number) + 26'sd9208368;
        n_stage[0].b1 = b1_sum[24:0];
        if (din.operation == shdn_pkg::OP_TO_DN && (din.in_year == 16'sd0
                || din.in_month == 4'd0 || din.in_month > 4'd12 || din.in_day == 5'd0)) begin
            n_stage[0].st = shdn_pkg::ST_BAD_DATE;
        end else begin
            n_stage[0].st = shdn_pkg::ST_OK;
        end

        // stage 1: cycle quotients
        n_stage[1] = r_stage[0];
        prod0 = 36'(r_stage[0].b0) * 36'(shdn_pkg::RECIP_2820);
        prod1 = 51'(r_stage[0].b1) * 51'(shdn_pkg::RECIP_CYCLE);
        n_stage[1].q0 = prod0[34:30];
        n_stage[1].q1 = prod1[49:45];

        // stage 2: remainders within the cycle
        n_stage[2] = r_stage[1];
        rem0 = r_stage[1].b0 - 17'(17'(r_stage[1].q0) * 17'(shdn_pkg::CYCLE_YEARS));
        n_stage[2].ey = 12'(rem0) + 12'(shdn_pkg::BASE_YEAR);
        n_stage[2].cday = 20'(r_stage[1].b1 - 25'(25'(r_stage[1].q1)
                          * 25'(shdn_pkg::CYCLE_DAYS)));
        n_stage[2].cyc = (r_stage[1].op == shdn_pkg::OP_TO_DATE)
                       ? $signed(r_stage[1].q1 - 5'd11) : $signed(r_stage[1].q0 - 5'd12);
        n_stage[2].last = (n_stage[2].cday == 20'(shdn_pkg::CYCLE_DAYS - 1));

        // stage 3
        n_stage[3] = r_stage[2];
        prod2 = 41'(r_stage[2].cday) * 41'(shdn_pkg::RECIP_366);
        n_stage[3].a1 = prod2[40:29];
        n_stage[3].dcyc = 25'(r_stage[2].cyc) * 25'(shdn_pkg::CYCLE_DAYS);

        // stage 4
        n_stage[4] = r_stage[3];
        n_stage[4].a2 = 9'(r_stage[3].cday - 20'(r_stage[3].a1) * 20'd366);

        // stage 5
        n_stage[5] = r_stage[4];
        n_stage[5].num = 23'(r_stage[4].a1) * 23'd2134 + 23'(r_stage[4].a2) * 23'd2816
                       + 23'd2815;

        // stage 6: year in cycle, quotient is at most 6
        n_stage[6] = r_stage[5];
        cnt = '0;
        for (int k = 1; k <= 6; k++) begin
            if (r_stage[5].num >= 23'(k * shdn_pkg::YEAR_FRAC_DEN)) cnt = cnt + 3'd1;
        end
        n_stage[6].ycyc = r_stage[5].last ? 12'(shdn_pkg::CYCLE_YEARS)
                        : 12'(r_stage[5].a1) + 12'(cnt) + 12'd1;

        // stage 7: year of a day number (no year zero)
        n_stage[7] = r_stage[6];
        yr_raw = $signed(18'(r_stage[6].ycyc)) + 18'(r_stage[6].cyc) * 18'sd2820 + 18'sd474;
        yr_adj = (yr_raw <= 18'sd0) ? yr_raw - 18'sd1 : yr_raw;
        if (r_stage[6].op == shdn_pkg::OP_TO_DATE) begin
            n_stage[7].ey = (r_stage[6].ycyc == 12'(shdn_pkg::CYCLE_YEARS))
                          ? 12'(shdn_pkg::BASE_YEAR)
                          : r_stage[6].ycyc + 12'(shdn_pkg::BASE_YEAR);
            n_stage[7].year = 17'(yr_adj);
            if (yr_adj < -18'sd32768 || yr_adj > 18'sd32767) begin
                n_stage[7].st = shdn_pkg::ST_RANGE;
            end
        end

        // stage 8
        n_stage[8] = r_stage[7];
        n_stage[8].pf = 22'(r_stage[7].ey) * 22'd682 - 22'd110;
        n_stage[8].pv = (22'(r_stage[7].ey) + 22'd38) * 22'd682;

        // stage 9: divide by 2816 as shift by 8 then by 11
        n_stage[9] = r_stage[8];
        prodf = 27'(r_stage[8].pf[21:8]) * 27'(shdn_pkg::RECIP_11);
        prodv = 27'(r_stage[8].pv[21:8]) * 27'(shdn_pkg::RECIP_11);
        n_stage[9].qf = prodf[25:16];
        n_stage[9].qv = prodv[25:16];

        // stage 10
        n_stage[10] = r_stage[9];
        remv = r_stage[9].pv - 22'(r_stage[9].qv) * 22'd2816;
        n_stage[10].leap = (remv < 22'd682);
        n_stage[10].fy = 21'(r_stage[9].ey - 12'd1) * 21'd365 + 21'(r_stage[9].qf);

        // stage 11: day number of a date, or day of year of a day number
        n_stage[11] = r_stage[10];
        yday_sum = 22'(r_stage[10].cday) - 22'(r_stage[10].fy) + 22'd173126;
        if (r_stage[10].op == shdn_pkg::OP_TO_DN) begin
            if (r_stage[10].st == shdn_pkg::ST_OK
                    && r_stage[10].day > shdn_pkg::month_len(r_stage[10].month,
                                                             r_stage[10].leap)) begin
                n_stage[11].st = shdn_pkg::ST_BAD_DATE;
            end
            n_stage[11].dn = $signed(26'(r_stage[10].day))
                           + $signed(26'(shdn_pkg::days_before_month(r_stage[10].month)))
                           + $signed(26'(r_stage[10].fy))
                           + 26'(r_stage[10].dcyc)
                           + 26'(shdn_pkg::EPOCH_BEFORE);
        end else begin
            // the last year of a cycle starts one cycle length earlier
            n_stage[11].yday = (r_stage[10].ycyc == 12'(shdn_pkg::CYCLE_YEARS))
                             ? yday_sum[8:0] - 9'(shdn_pkg::CYCLE_DAYS) : yday_sum[8:0];
        end

        // stage 12
        n_stage[12] = r_stage[11];
        ydm1 = 8'(r_stage[11].yday - 9'd1);
        ydm2 = 8'(r_stage[11].yday - 9'd187);
        pm1  = 20'(ydm1) * 20'(shdn_pkg::RECIP_31);
        pm2  = 20'(ydm2) * 20'(shdn_pkg::RECIP_30);
        m_lo = pm1[19:16] + 4'd1;
        m_hi = pm2[19:16] + 4'd7;
        if (r_stage[11].op == shdn_pkg::OP_TO_DN) begin
            if (r_stage[11].st == shdn_pkg::ST_OK && (r_stage[11].dn < -26'sd8388608
                    || r_stage[11].dn > 26'sd8388607)) begin
                n_stage[12].st = shdn_pkg::ST_RANGE;
            end
        end else begin
            n_stage[12].month = (r_stage[11].yday <= 9'd186) ? m_lo
                              : ((m_hi > 4'd12) ? 4'd12 : m_hi);
        end
        w7_sum = 26'($signed(r_stage[11].dn[23:0])) + 26'sd8388613;
        n_stage[12].w7 = w7_sum[24:0];

        // stage 13
        n_stage[13] = r_stage[12];
        if (r_stage[12].op == shdn_pkg::OP_TO_DATE) begin
            n_stage[13].day = 5'(r_stage[12].yday
                            - shdn_pkg::days_before_month(r_stage[12].month));
        end
        n_stage[13].mlen = shdn_pkg::month_len(r_stage[12].month, r_stage[12].leap);
        prodw = 50'(r_stage[12].w7) * 50'(shdn_pkg::RECIP_7);
        n_stage[13].qw = prodw[48:27];

        // stage 14
        n_stage[14] = r_stage[13];
        n_stage[14].wd = 3'(r_stage[13].w7 - 25'(r_stage[13].qw) * 25'd7);

        // stage 15: festivals; last Wednesday of Esfand from the weekday of its last day
        n_stage[15] = r_stage[14];
        wdl  = 6'(r_stage[14].wd) + 6'(r_stage[14].mlen) - 6'(r_stage[14].day);
        back = shdn_pkg::mod7_small(shdn_pkg::mod7_small(wdl) + 6'd3);
        wed  = r_stage[14].mlen - 5'(back);
        priority if (r_stage[14].month == 4'd1 && r_stage[14].day == 5'd1) begin
            n_stage[15].fest = shdn_pkg::FEST_NOWRUZ;
        end else if (r_stage[14].month == 4'd1 && r_stage[14].day == 5'd13) begin
            n_stage[15].fest = shdn_pkg::FEST_SIZDAH;
        end else if (r_stage[14].month == 4'd9 && r_stage[14].day == 5'd30) begin
            n_stage[15].fest = shdn_pkg::FEST_YALDA;
        end else if (r_stage[14].month == 4'd12 && r_stage[14].day == wed) begin
            n_stage[15].fest = shdn_pkg::FEST_SURI;
        end else begin
            n_stage[15].fest = shdn_pkg::FEST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < shdn_pkg::STAGES; k++) begin
            if (ctl.load[k]) r_stage[k] <= n_stage[k];
        end
    end

    always_comb begin
        o_out.data = '0;
        o_out.data.status = r_stage[LAST].st;
        if (r_stage[LAST].st == shdn_pkg::ST_OK) begin
            o_out.data.out_year       = r_stage[LAST].year[15:0];
            o_out.data.out_month      = r_stage[LAST].month;
            o_out.data.out_day        = r_stage[LAST].day;
            o_out.data.out_day_number = r_stage[LAST].dn[23:0];
            o_out.data.weekday        = r_stage[LAST].wd;
            o_out.data.is_leap        = r_stage[LAST].leap;
            o_out.data.month_length   = r_stage[LAST].mlen;
            o_out.data.year_length    = r_stage[LAST].leap ? 9'd366 : 9'd365;
            o_out.data.festival       = r_stage[LAST].fest;
        end
    end

    assign o_out.valid = ctl.valid[LAST];

    `SHDN_ASSERT(a_fail_zeroed, i_clk, i_rst_n,
        (o_out.valid && o_out.data.status != shdn_pkg::ST_OK) |->
        (o_out.data.out_year == 16'sd0 && o_out.data.out_day_number == 24'sd0
         && o_out.data.year_length == 9'd0))
    `SHDN_ASSERT(a_ok_date_sane, i_clk, i_rst_n,
        (o_out.valid && o_out.data.status == shdn_pkg::ST_OK) |->
        (o_out.data.out_day != 5'd0 && o_out.data.out_day <= o_out.data.month_length
         && o_out.data.out_month >= 4'd1 && o_out.data.out_month <= 4'd12
         && o_out.data.out_year != 16'sd0 && o_out.data.weekday <= 3'd6))
    `SHDN_ASSERT(a_leap_len, i_clk, i_rst_n,
        (o_out.valid && o_out.data.status == shdn_pkg::ST_OK) |->
        (o_out.data.year_length == (o_out.data.is_leap ? 9'd366 : 9'd365)))
    `SHDN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out.valid)
endmodule
